/* design/pbw_pkg.sv */
`timescale 1ns / 1ps

package pbw_pkg;

  // Resolution of the triangle before it is scaled into the level span.
  localparam int VALUE_BITS = 16;
  localparam logic [VALUE_BITS-1:0] FULL_SCALE = {VALUE_BITS{1'b1}};

  localparam int TIME_W  = 32;
  localparam int MS_W    = 24;
  localparam int LEVEL_W = 16;
  localparam int PHASE_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  // The cycle sum of three 24 bit values needs 26 bits.
  localparam int DIV_DW = MS_W + 2;
  // The widest dividend is the ramp offset times full scale.
  localparam int DIV_NW = (MS_W + VALUE_BITS > TIME_W) ? MS_W + VALUE_BITS : TIME_W;

  localparam int PROD_W = VALUE_BITS + LEVEL_W;

  // Partial remainders of the division by full scale. Folding the high part of
  // the product onto the low part twice leaves a value below three full scales.
  localparam int FOLD_W = ((VALUE_BITS > LEVEL_W) ? VALUE_BITS : LEVEL_W) + 1;
  localparam logic [FOLD_W-1:0] FOLD_FS  = FOLD_W'(FULL_SCALE);
  localparam logic [FOLD_W-1:0] FOLD_FS2 = FOLD_W'({FULL_SCALE, 1'b0});

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DWELL_BEFORE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DWELL_AFTER  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LEVEL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_SHIFT  = 3'd5;

  // Flags that ride along with an item through the dividers.
  typedef struct packed {
    logic in_band;
    logic rising;
  } side_t;

endpackage

/* design/pbw_div.sv */
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per stage, DIV_NW stages.
module pbw_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [pbw_pkg::DIV_NW-1:0]   dividend,
  input  logic [pbw_pkg::DIV_DW-1:0]   divisor,
  input  pbw_pkg::side_t               in_side,
  output logic                         out_valid,
  output logic [pbw_pkg::DIV_NW-1:0]   quotient,
  output logic [pbw_pkg::DIV_DW-1:0]   remainder,
  output pbw_pkg::side_t               out_side
);
  import pbw_pkg::*;

  logic [DIV_NW-1:0] vld;
  logic [DIV_NW-1:0] num      [DIV_NW];
  logic [DIV_DW-1:0] rem      [DIV_NW];
  side_t             side     [DIV_NW];
  logic [DIV_NW-1:0] num_next [DIV_NW];
  logic [DIV_DW-1:0] rem_next [DIV_NW];

  always_comb begin
    logic [DIV_NW-1:0] src_num;
    logic [DIV_DW-1:0] src_rem;
    logic [DIV_DW:0]   trial;
    logic              ge;
    for (int k = 0; k < DIV_NW; k++) begin
      src_num = (k == 0) ? dividend : num[(k == 0) ? 0 : k - 1];
      src_rem = (k == 0) ? '0 : rem[(k == 0) ? 0 : k - 1];
      trial = {src_rem, src_num[DIV_NW-1]};
      ge = trial >= {1'b0, divisor};
      num_next[k] = {src_num[DIV_NW-2:0], ge};
      rem_next[k] = ge ? DIV_DW'(trial - {1'b0, divisor}) : trial[DIV_DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DIV_NW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_NW; k++) begin
        num[k]  <= num_next[k];
        rem[k]  <= rem_next[k];
        side[k] <= (k == 0) ? in_side : side[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign out_valid = vld[DIV_NW-1];
  assign quotient  = num[DIV_NW-1];
  assign remainder = rem[DIV_NW-1];
  assign out_side  = side[DIV_NW-1];

endmodule

/* design/paused_triangle_breathing_wave.sv */
`timescale 1ns / 1ps

// Triangle breathing wave with dwell times. Each transfer on the time channel
// (time_valid, time_stall, time_ms) yields exactly one transfer on the level
// channel (level_valid, level_stall, level), in order.
// Configuration goes through cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high, and registers should only be changed while no
// item is in flight, since the pipeline reads them at several points.
// Throughput is one item per cycle while the receiver does not stall. The
// pipeline holds three restoring dividers that each resolve one quotient bit
// per stage: time modulo cycle sum, ramp position modulo period, and ramp
// scaling by half period. The span scaling by full scale folds the product
// in two stages and corrects it in the output register.
// The whole pipeline advances together. When the receiver stalls while a
// result is held in the output register, every stage freezes and time_stall
// is raised, so nothing is lost or repeated. Bubbles travel as invalid slots.
// Reset empties the pipeline and loads the default configuration: period
// 1000 ms, no dwells, low level 0, high level 65535, no phase shift.
module paused_triangle_breathing_wave (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             time_valid,
  output logic                             time_stall,
  input  logic [pbw_pkg::TIME_W-1:0]       time_ms,
  output logic                             level_valid,
  input  logic                             level_stall,
  output logic [pbw_pkg::LEVEL_W-1:0]      level,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pbw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pbw_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pbw_pkg::*;

  // Configuration registers.
  logic [MS_W-1:0]    period_ms;
  logic [MS_W-1:0]    dwell_before_ms;
  logic [MS_W-1:0]    dwell_after_ms;
  logic [LEVEL_W-1:0] low_level;
  logic [LEVEL_W-1:0] high_level;
  logic [PHASE_W-1:0] phase_shift;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_ms       <= MS_W'(1000);
      dwell_before_ms <= '0;
      dwell_after_ms  <= '0;
      low_level       <= '0;
      high_level      <= '1;
      phase_shift     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PERIOD:       period_ms       <= cfg_data;
        REG_DWELL_BEFORE: dwell_before_ms <= cfg_data;
        REG_DWELL_AFTER:  dwell_after_ms  <= cfg_data;
        REG_LOW_LEVEL:    low_level       <= cfg_data[LEVEL_W-1:0];
        REG_HIGH_LEVEL:   high_level      <= cfg_data[LEVEL_W-1:0];
        REG_PHASE_SHIFT:  phase_shift     <= cfg_data[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  // Values derived from the configuration alone.
  logic [DIV_DW-1:0]  cycle_sum;
  logic [DIV_DW-1:0]  band_end;
  logic [MS_W-2:0]    half;
  logic [LEVEL_W-1:0] span;
  logic               degenerate;

  assign cycle_sum  = DIV_DW'(dwell_before_ms) + DIV_DW'(period_ms) + DIV_DW'(dwell_after_ms);
  assign band_end   = DIV_DW'(dwell_before_ms) + DIV_DW'(period_ms);
  assign half       = period_ms[MS_W-1:1];
  assign span       = high_level - low_level;
  // An empty cycle, a period too short to ramp, or an inverted span all
  // hold the output at the low level.
  assign degenerate = (cycle_sum == '0) || (high_level < low_level) || (period_ms < MS_W'(2));

  // The pipeline moves as one unit unless a finished result is being held.
  logic en;
  assign en         = !(level_valid && level_stall);
  assign time_stall = !en;

  // Position inside the cycle.
  logic               a_valid;
  logic [DIV_NW-1:0]  a_quot;
  logic [DIV_DW-1:0]  a_rem;
  side_t              a_side;

  pbw_div u_pos_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (time_valid),
    .dividend  (DIV_NW'(time_ms)),
    .divisor   (cycle_sum),
    .in_side   ('0),
    .out_valid (a_valid),
    .quotient  (a_quot),
    .remainder (a_rem),
    .out_side  (a_side)
  );

  // Offset into the breathing part plus the phase shift.
  logic              b_valid;
  logic [MS_W:0]     b_shifted;
  logic              b_in_band;
  logic [DIV_DW-1:0] pos_off;

  assign pos_off = a_rem - DIV_DW'(dwell_before_ms);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_in_band <= (a_rem >= DIV_DW'(dwell_before_ms)) && (a_rem < band_end);
      b_shifted <= (MS_W + 1)'(pos_off[MS_W-1:0]) + (MS_W + 1)'(phase_shift);
    end
  end

  // Wrap the shifted offset into the period.
  logic              c_valid;
  logic [DIV_NW-1:0] c_quot;
  logic [DIV_DW-1:0] c_rem;
  side_t             c_side;
  side_t             b_side;

  assign b_side = '{in_band: b_in_band, rising: 1'b0};

  pbw_div u_wrap_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (b_valid),
    .dividend  (DIV_NW'(b_shifted)),
    .divisor   (DIV_DW'(period_ms)),
    .in_side   (b_side),
    .out_valid (c_valid),
    .quotient  (c_quot),
    .remainder (c_rem),
    .out_side  (c_side)
  );

  // Pick the rising or falling half and form the distance along it.
  logic          d_valid;
  logic [MS_W-1:0] d_dist;
  side_t         d_side;
  logic          ct_rising;

  assign ct_rising = c_rem < DIV_DW'(half);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_side <= '{in_band: c_side.in_band, rising: ct_rising};
      d_dist <= ct_rising ? c_rem[MS_W-1:0] : MS_W'(c_rem - DIV_DW'(half));
    end
  end

  // Scale the distance to full scale.
  logic              e_valid;
  logic [DIV_NW-1:0] e_num;
  side_t             e_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_side <= d_side;
      e_num  <= DIV_NW'(d_dist) * DIV_NW'(FULL_SCALE);
    end
  end

  logic              f_valid;
  logic [DIV_NW-1:0] f_quot;
  logic [DIV_DW-1:0] f_rem;
  side_t             f_side;

  pbw_div u_ramp_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (e_valid),
    .dividend  (e_num),
    .divisor   (DIV_DW'(half)),
    .in_side   (e_side),
    .out_valid (f_valid),
    .quotient  (f_quot),
    .remainder (f_rem),
    .out_side  (f_side)
  );

  // Triangle value; the quotient never exceeds full scale.
  logic                  g_valid;
  logic [VALUE_BITS-1:0] g_tri;
  side_t                 g_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (en) begin
      g_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_side <= f_side;
      g_tri  <= f_side.rising ? f_quot[VALUE_BITS-1:0] : FULL_SCALE - f_quot[VALUE_BITS-1:0];
    end
  end

  // Scale the triangle into the level span.
  logic              h_valid;
  logic [PROD_W-1:0] h_prod;
  side_t             h_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
    end else if (en) begin
      h_valid <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_side <= g_side;
      h_prod <= PROD_W'(g_tri) * PROD_W'(span);
    end
  end

  // Divide the product by full scale. Since 2^VALUE_BITS is one more than full
  // scale, each fold adds the high part to both the quotient and the low part.
  // After two folds the remainder is below three full scales.
  logic               m_valid;
  logic [LEVEL_W-1:0] m_quot;
  logic [FOLD_W-1:0]  m_rem;
  side_t              m_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= h_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_side <= h_side;
      m_quot <= h_prod[PROD_W-1:VALUE_BITS];
      m_rem  <= FOLD_W'(h_prod[VALUE_BITS-1:0]) + FOLD_W'(h_prod[PROD_W-1:VALUE_BITS]);
    end
  end

  logic               n_valid;
  logic [LEVEL_W-1:0] n_quot;
  logic [FOLD_W-1:0]  n_rem;
  side_t              n_side;
  logic [LEVEL_W-1:0] n_fix;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_valid <= 1'b0;
    end else if (en) begin
      n_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_side <= m_side;
      n_quot <= m_quot + LEVEL_W'(m_rem >> VALUE_BITS);
      n_rem  <= FOLD_W'(m_rem[VALUE_BITS-1:0]) + (m_rem >> VALUE_BITS);
    end
  end

  // Whole full scales still left in the remainder.
  assign n_fix = LEVEL_W'(n_rem >= FOLD_FS) + LEVEL_W'(n_rem >= FOLD_FS2);

  // Output register. Dwells and degenerate settings give the low level.
  always_ff @(posedge clk) begin
    if (rst) begin
      level_valid <= 1'b0;
    end else if (en) begin
      level_valid <= n_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (degenerate || !n_side.in_band) begin
        level <= low_level;
      end else begin
        level <= low_level + n_quot + n_fix;
      end
    end
  end

endmodule

/* bench/pbw_level_checker.sv */
`timescale 1ns / 1ps

// Watches the time, level and register channels of the breathing wave block,
// keeps its own copy of the registers, predicts one level per accepted time
// and compares each level transfer against the oldest prediction.
module pbw_level_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           time_valid,
  input  logic                           time_stall,
  input  logic [pbw_pkg::TIME_W-1:0]     time_ms,
  input  logic                           level_valid,
  input  logic                           level_stall,
  input  logic [pbw_pkg::LEVEL_W-1:0]    level,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [pbw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pbw_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fails,
  output int                             pending
);
  import pbw_pkg::*;

  logic [MS_W-1:0]    period_r, dwell_pre_r, dwell_post_r;
  logic [LEVEL_W-1:0] low_r, high_r;
  logic [PHASE_W-1:0] shift_r;

  logic [LEVEL_W-1:0] expected_levels[$];
  int                 level_count;

  function automatic logic [LEVEL_W-1:0] breathing_level(input logic [TIME_W-1:0] t);
    longint unsigned fs, cyc, pos, ct, half, tri_v;
    fs = (64'd1 << VALUE_BITS) - 1;
    cyc = longint'(dwell_pre_r) + period_r + dwell_post_r;
    if (cyc == 0 || high_r < low_r) return low_r;
    pos = longint'(t) % cyc;
    if (pos < dwell_pre_r || pos >= longint'(dwell_pre_r) + period_r) return low_r;
    if (period_r < 2) return low_r;
    ct = ((pos - dwell_pre_r) + shift_r) % period_r;
    half = period_r / 2;
    if (ct < half) tri_v = (ct * fs) / half;
    else tri_v = fs - ((ct - half) * fs) / half;
    return LEVEL_W'(low_r + (tri_v * (high_r - low_r)) / fs);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] level mismatch: %s", $realtime, msg);
    fails++;
  endtask

  initial begin
    fails = 0;
    level_count = 0;
  end

  assign pending = expected_levels.size();

  always @(posedge clk) begin
    if (rst) begin
      period_r <= MS_W'(1000);
      dwell_pre_r <= '0;
      dwell_post_r <= '0;
      low_r <= '0;
      high_r <= '1;
      shift_r <= '0;
      expected_levels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PERIOD:       period_r <= cfg_data;
          REG_DWELL_BEFORE: dwell_pre_r <= cfg_data;
          REG_DWELL_AFTER:  dwell_post_r <= cfg_data;
          REG_LOW_LEVEL:    low_r <= cfg_data[LEVEL_W-1:0];
          REG_HIGH_LEVEL:   high_r <= cfg_data[LEVEL_W-1:0];
          REG_PHASE_SHIFT:  shift_r <= cfg_data[PHASE_W-1:0];
          default: ;
        endcase
      end
      if (time_valid && !time_stall)
        expected_levels.push_back(breathing_level(time_ms));
      if (level_valid && !level_stall) begin
        level_count++;
        if (expected_levels.size() == 0)
          report_mismatch($sformatf("level %0d with no time waiting", level));
        else begin
          if (level !== expected_levels[0])
            report_mismatch($sformatf("result %0d got %0d want %0d",
                                      level_count, level, expected_levels[0]));
          void'(expected_levels.pop_front());
        end
      end
    end
  end

endmodule

/* bench/paused_triangle_breathing_wave_tb.sv */
`timescale 1ns / 1ps

// Top of the bench. It drives time values and register writes, pulls levels
// with random stalls, and gives the verdict from the checker's failure count.
module paused_triangle_breathing_wave_tb;
  import pbw_pkg::*;

  // Deep enough to cover the pipeline latency of the block.
  localparam int DRAIN_CYCLES = 3 * DIV_NW + 40;

  logic                  clk;
  logic                  rst;
  logic                  time_valid;
  logic                  time_stall;
  logic [TIME_W-1:0]     time_ms;
  logic                  level_valid;
  logic                  level_stall;
  logic [LEVEL_W-1:0]    level;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fails;
  int pending;
  int times_sent;
  int settings_used;
  bit send_no_idle;
  bit take_no_idle;
  bit hold_req;
  bit hold_done;

  paused_triangle_breathing_wave u_top (
    .clk(clk), .rst(rst),
    .time_valid(time_valid), .time_stall(time_stall), .time_ms(time_ms),
    .level_valid(level_valid), .level_stall(level_stall), .level(level),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pbw_level_checker u_checker (
    .clk(clk), .rst(rst),
    .time_valid(time_valid), .time_stall(time_stall), .time_ms(time_ms),
    .level_valid(level_valid), .level_stall(level_stall), .level(level),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Hard limit on the run: far above the slowest legal run of this bench.
  initial begin
    #20_000_000;
    $display("Timeout with %0d levels still expected", pending);
    $display("FAIL");
    $finish;
  end

  // Offers one time value. We enter on a rising edge and leave on the edge at
  // which the transfer happened, so a back-to-back item keeps time_valid high
  // with a single assignment in that step. The stall is looked at on the
  // falling edge, where it already holds its value for the coming rising edge.
  task automatic send_time(input logic [TIME_W-1:0] t);
    int gap;
    gap = send_no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      time_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    time_valid <= 1'b1;
    time_ms <= t;
    do @(negedge clk); while (time_stall);
    @(posedge clk);
    times_sent++;
    if (times_sent % 60 == 0) send_no_idle = ($urandom_range(0, 3) == 0);
  endtask

  // Register writes go out back to back; the caller drops cfg_valid after.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
  endtask

  // Registers may only change while nothing is in flight. Every time value
  // yields one level, so an empty prediction queue means the pipeline is empty;
  // a few more cycles are allowed anyway before the new setting goes in.
  task automatic load_setting(input logic [MS_W-1:0] per, input logic [MS_W-1:0] pre,
                              input logic [MS_W-1:0] post, input logic [CFG_DATA_W-1:0] lo,
                              input logic [CFG_DATA_W-1:0] hi, input logic [CFG_DATA_W-1:0] sh);
    time_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    write_reg(REG_PERIOD, per);
    write_reg(REG_DWELL_BEFORE, pre);
    write_reg(REG_DWELL_AFTER, post);
    write_reg(REG_LOW_LEVEL, lo);
    write_reg(REG_HIGH_LEVEL, hi);
    write_reg(REG_PHASE_SHIFT, sh);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [MS_W-1:0] pick_ms(input bit short_range);
    return short_range ? MS_W'($urandom_range(0, 40)) : MS_W'($urandom);
  endfunction

  // Receiver: a random stall before each level transfer, with stretches of
  // none, and one long hold-off so the pipeline fills and stalls its input.
  initial begin : receiver
    int w;
    level_stall = 1'b1;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        w = 400;
        hold_done = 1'b1;
      end else
        w = take_no_idle ? 0 : $urandom_range(0, 12);
      if (w > 0) begin
        level_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      level_stall <= 1'b0;
      do @(negedge clk); while (!level_valid);
      @(posedge clk);
      if ($urandom_range(0, 59) == 0) take_no_idle = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin : stimulus
    logic [TIME_W-1:0] t;
    bit short_range;
    int n;
    times_sent = 0;
    settings_used = 1;
    send_no_idle = 1'b0;
    take_no_idle = 1'b0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    rst = 1'b1;
    time_valid = 1'b0;
    time_ms = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_PERIOD;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset setting: ramp edges, peak, wrap of the period and the time extremes.
    send_time(32'd0);
    send_time(32'd1);
    send_time(32'd499);
    send_time(32'd500);
    send_time(32'd999);
    send_time(32'd1000);
    send_time(32'h8000_0000);
    send_time(32'hFFFF_FFFF);

    // Odd period between both dwells, with the largest phase shift.
    load_setting(24'd7, 24'd3, 24'd5, 24'd100, 24'd60000, 24'hFFFF);
    for (int i = 0; i < 15; i++) send_time(TIME_W'(i));

    // Zero cycle sum, then a period of one, then high below low.
    load_setting(24'd0, 24'd0, 24'd0, 24'd77, 24'd900, 24'd0);
    send_time(32'd0);
    send_time(32'hFFFF_FFFF);
    load_setting(24'd1, 24'd2, 24'd0, 24'd5, 24'd10, 24'd3);
    for (int i = 0; i < 3; i++) send_time(TIME_W'(i));
    load_setting(24'd10, 24'd0, 24'd0, 24'd500, 24'd400, 24'd0);
    send_time(32'd3);
    send_time(32'd5);

    // Largest values in every register; then the largest period, high level and phase shift, no dwells, low level 0.
    load_setting(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFF, 24'hFFFF, 24'hFFFF);
    send_time(32'h00FF_FFFF);
    send_time(32'h01FF_FFFF);
    load_setting(24'hFFFFFF, 24'd0, 24'd0, 24'd0, 24'hFFFF, 24'hFFFF);
    send_time(32'h007F_FFFF);
    send_time(32'hFFFF_FFFF);

    // Random settings, each with a batch of random time values. Short periods
    // and dwells keep a good share of the times inside the breathing part.
    for (int ph = 0; ph < 10; ph++) begin
      short_range = ($urandom_range(0, 2) != 0);
      load_setting(pick_ms(short_range), pick_ms(short_range && $urandom_range(0, 1)),
                   pick_ms(short_range && $urandom_range(0, 1)),
                   CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
      n = 130;
      for (int i = 0; i < n; i++) begin
        t = ($urandom_range(0, 3) == 0) ? TIME_W'($urandom_range(0, 200)) : TIME_W'($urandom);
        if (ph == 4 && i == 20) hold_req = 1'b1;
        send_time(t);
      end
    end
    time_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d time values over %0d register settings,", times_sent, settings_used);
    $display("including dwells, odd and tiny periods, zero cycle and inverted levels.");
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", fails);
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
design/pbw_pkg.sv
design/pbw_div.sv
design/paused_triangle_breathing_wave.sv
bench/pbw_level_checker.sv
bench/paused_triangle_breathing_wave_tb.sv
